/* sv/tmau_pkg.sv */
// Shared types and constants for the trackball motion accelerator unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tmau_pkg;

    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MUL_A_W   = 18;
    localparam int unsigned MUL_B_W   = 10;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic [15:0] SCALE_LIMIT = 16'd16384;
    localparam int unsigned BUTTON_BIT  = 7;

    localparam logic [2:0] REG_BASE_GAIN       = 3'd0;
    localparam logic [2:0] REG_ACCEL_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_ACCEL_POWER     = 3'd2;
    localparam logic [2:0] REG_SWAP_AXES       = 3'd3;
    localparam logic [2:0] REG_NEGATE_X        = 3'd4;
    localparam logic [2:0] REG_NEGATE_Y        = 3'd5;

    localparam logic [1:0] KIND_REL_X  = 2'd0;
    localparam logic [1:0] KIND_REL_Y  = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    typedef struct packed {
        logic [7:0] left_count;
        logic [7:0] right_count;
        logic [7:0] up_count;
        logic [7:0] down_count;
        logic [7:0] switch_byte;
    } tmau_in_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic signed [15:0] event_value;
        logic               sync_flag;
        logic               last_of_run;
    } tmau_out_t;

    typedef struct packed {
        logic [15:0] base_gain;
        logic [15:0] accel_threshold;
        logic [7:0]  accel_power;
        logic        swap_axes;
        logic        negate_x;
        logic        negate_y;
    } tmau_cfg_t;

endpackage

`default_nettype wire

/* sv/tmau_regs.sv */
// Configuration register file with an APB-style slave port.
// Depends on tmau_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module tmau_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tmau_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tmau_pkg::DATA_W-1:0] pwdata,
    output logic      [tmau_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output tmau_pkg::tmau_cfg_t             cfg
);
    import tmau_pkg::*;

    tmau_cfg_t  cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_gain       <= 16'd16;
            cfg_reg.accel_threshold <= 16'd0;
            cfg_reg.accel_power     <= 8'd0;
            cfg_reg.swap_axes       <= 1'b0;
            cfg_reg.negate_x        <= 1'b0;
            cfg_reg.negate_y        <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BASE_GAIN:       cfg_reg.base_gain       <= pwdata[15:0];
                REG_ACCEL_THRESHOLD: cfg_reg.accel_threshold <= pwdata[15:0];
                REG_ACCEL_POWER:     cfg_reg.accel_power     <= pwdata[7:0];
                REG_SWAP_AXES:       cfg_reg.swap_axes       <= pwdata[0];
                REG_NEGATE_X:        cfg_reg.negate_x        <= pwdata[0];
                REG_NEGATE_Y:        cfg_reg.negate_y        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BASE_GAIN:       prdata = {16'd0, cfg_reg.base_gain};
            REG_ACCEL_THRESHOLD: prdata = {16'd0, cfg_reg.accel_threshold};
            REG_ACCEL_POWER:     prdata = {24'd0, cfg_reg.accel_power};
            REG_SWAP_AXES:       prdata = {31'd0, cfg_reg.swap_axes};
            REG_NEGATE_X:        prdata = {31'd0, cfg_reg.negate_x};
            REG_NEGATE_Y:        prdata = {31'd0, cfg_reg.negate_y};
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/tmau_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on tmau_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module tmau_mul (
    input  wire logic                                aclk,
    input  wire logic                                load,
    input  wire logic signed [tmau_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [tmau_pkg::MUL_B_W-1:0] op_b,
    output logic      signed [tmau_pkg::MUL_P_W-1:0] prod
);
    import tmau_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
        end
    end

endmodule

`default_nettype wire

/* sv/tmau_seq.sv */
// Sequencer: magnitude, power loop, axis scaling and event emission.
// Depends on tmau_pkg and drives the shared multiplier tmau_mul.
`timescale 1ns / 1ps
`default_nettype none

module tmau_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tmau_pkg::tmau_cfg_t cfg,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tmau_pkg::tmau_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tmau_pkg::tmau_out_t      m_data
);
    import tmau_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAG, ST_POW, ST_SUM, ST_MULX, ST_MULY, ST_FINY, ST_POST, ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic signed [8:0]  dx_reg, dx_next;
    logic signed [8:0]  dy_reg, dy_next;
    logic               pressed_reg, pressed_next;
    logic               btn_reg, btn_next;
    logic [8:0]         over_reg, over_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [15:0]        pt_reg, pt_next;
    logic [15:0]        s_reg, s_next;
    logic [15:0]        ox_reg, ox_next;
    logic [15:0]        oy_reg, oy_next;
    logic [2:0]         pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    tmau_out_t          m_data_reg, m_data_next;

    logic                      mul_load;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic [7:0]  ax, ay, hi, lo;
    logic [11:0] hi15, lo15;
    logic [8:0]  mag;
    logic [16:0] sum;
    logic [15:0] fx, fy;
    logic [2:0]  pend_left;

    function automatic logic [15:0] scale_sat(input logic signed [MUL_P_W-1:0] p);
        logic signed [MUL_P_W-1:0] adj;
        logic signed [MUL_P_W-5:0] q;
        adj = p[MUL_P_W-1] ? p + MUL_P_W'(15) : p;
        q   = adj[MUL_P_W-1:4];
        if (q > (MUL_P_W-4)'(32767)) begin
            return 16'h7FFF;
        end else if (q < -(MUL_P_W-4)'(32768)) begin
            return 16'h8000;
        end else begin
            return q[15:0];
        end
    endfunction

    tmau_mul u_mul (
        .aclk (aclk),
        .load (mul_load),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        ax   = dx_reg[8] ? 8'(-dx_reg) : dx_reg[7:0];
        ay   = dy_reg[8] ? 8'(-dy_reg) : dy_reg[7:0];
        hi   = (ax > ay) ? ax : ay;
        lo   = (ax > ay) ? ay : ax;
        hi15 = {hi, 4'd0} - {4'd0, hi};
        lo15 = {lo, 4'd0} - {4'd0, lo};
        mag  = {1'b0, hi15[11:4]} + {2'b0, lo15[11:5]};
        sum  = {1'b0, cfg.base_gain} + {1'b0, pt_reg};
        fx   = cfg.swap_axes ? oy_reg : ox_reg;
        fy   = cfg.swap_axes ? ox_reg : oy_reg;
        if (cfg.negate_x) begin
            fx = 16'(16'd0 - fx);
        end
        if (cfg.negate_y) begin
            fy = 16'(16'd0 - fy);
        end
    end

    always_comb begin
        mul_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_MAG: begin
                mul_load = 1'b1;
                mul_a    = MUL_A_W'(1);
                mul_b    = MUL_B_W'(1);
            end
            ST_POW: begin
                mul_load = 1'b1;
                mul_a    = {3'd0, mul_prod[14:0]};
                mul_b    = {1'b0, over_reg};
            end
            ST_MULX: begin
                mul_load = 1'b1;
                mul_a    = {2'd0, s_reg};
                mul_b    = MUL_B_W'(dx_reg);
            end
            ST_MULY: begin
                mul_load = 1'b1;
                mul_a    = {2'd0, s_reg};
                mul_b    = MUL_B_W'(dy_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        pressed_next = pressed_reg;
        btn_next     = btn_reg;
        over_next    = over_reg;
        cnt_next     = cnt_reg;
        pt_next      = pt_reg;
        s_next       = s_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pend_left    = pend_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dx_next      = {1'b0, s_data.right_count} - {1'b0, s_data.left_count};
                    dy_next      = {1'b0, s_data.down_count} - {1'b0, s_data.up_count};
                    pressed_next = s_data.switch_byte[BUTTON_BIT];
                    if (dx_next == 9'sd0 && dy_next == 9'sd0) begin
                        ox_next    = '0;
                        oy_next    = '0;
                        state_next = ST_POST;
                    end else if (cfg.accel_power == 8'd0 || cfg.accel_threshold == 16'd0) begin
                        s_next     = cfg.base_gain;
                        state_next = ST_MULX;
                    end else begin
                        state_next = ST_MAG;
                    end
                end
            end
            ST_MAG: begin
                over_next  = ({7'd0, mag} > cfg.accel_threshold)
                           ? 9'(mag - cfg.accel_threshold[8:0]) : 9'd0;
                cnt_next   = cfg.accel_power;
                state_next = ST_POW;
            end
            ST_POW: begin
                priority if (over_reg <= 9'd1) begin
                    pt_next    = {7'd0, over_reg};
                    state_next = ST_SUM;
                end else if (cnt_reg == 8'd0) begin
                    pt_next    = (mul_prod > MUL_P_W'(SCALE_LIMIT))
                               ? SCALE_LIMIT : mul_prod[15:0];
                    state_next = ST_SUM;
                end else if (mul_prod > MUL_P_W'(SCALE_LIMIT)) begin
                    pt_next    = SCALE_LIMIT;
                    state_next = ST_SUM;
                end else begin
                    cnt_next = cnt_reg - 8'd1;
                end
            end
            ST_SUM: begin
                s_next     = (sum > {1'b0, SCALE_LIMIT}) ? SCALE_LIMIT : sum[15:0];
                state_next = ST_MULX;
            end
            ST_MULX: begin
                state_next = ST_MULY;
            end
            ST_MULY: begin
                ox_next    = scale_sat(mul_prod);
                state_next = ST_FINY;
            end
            ST_FINY: begin
                oy_next    = scale_sat(mul_prod);
                state_next = ST_POST;
            end
            ST_POST: begin
                ox_next   = fx;
                oy_next   = fy;
                pend_next = {pressed_reg != btn_reg, fy != 16'd0, fx != 16'd0};
                btn_next  = pressed_reg;
                state_next = (pend_next == 3'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    priority if (pend_reg[0]) begin
                        pend_left                = {pend_reg[2:1], 1'b0};
                        m_data_next.event_kind   = KIND_REL_X;
                        m_data_next.event_value  = ox_reg;
                        m_data_next.sync_flag    = (oy_reg == 16'd0);
                    end else if (pend_reg[1]) begin
                        pend_left                = {pend_reg[2], 2'b0};
                        m_data_next.event_kind   = KIND_REL_Y;
                        m_data_next.event_value  = oy_reg;
                        m_data_next.sync_flag    = 1'b1;
                    end else begin
                        pend_left                = 3'd0;
                        m_data_next.event_kind   = KIND_BUTTON;
                        m_data_next.event_value  = {15'd0, btn_reg};
                        m_data_next.sync_flag    = 1'b1;
                    end
                    m_data_next.last_of_run = (pend_left == 3'd0);
                    m_valid_next = 1'b1;
                    pend_next    = pend_left;
                    if (pend_left == 3'd0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            btn_reg     <= 1'b0;
            pend_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            btn_reg     <= btn_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        pressed_reg <= pressed_next;
        over_reg    <= over_next;
        cnt_reg     <= cnt_next;
        pt_reg      <= pt_next;
        s_reg       <= s_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        m_data_reg  <= m_data_next;
    end

`ifndef SYNTHESIS
    a_no_accept_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 3'd0 |-> !s_ready)
        else $error("input accepted while events are pending");

    a_scale_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUM |=> s_reg <= SCALE_LIMIT)
        else $error("accelerated scale above limit");

    a_motion_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != KIND_BUTTON |-> m_data.event_value != 16'sd0)
        else $error("zero motion event emitted");

    a_button_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == KIND_BUTTON |->
        m_data.event_value == 16'sd0 || m_data.event_value == 16'sd1)
        else $error("button event value out of range");
`endif

endmodule

`default_nettype wire

/* sv/trackball_motion_accelerator_unit.sv */
// Trackball motion accelerator: each request is one trackball read (four
// motion counts and a switch byte); it yields zero to three events.
// The s_ channel takes requests with valid/ready; s_ready is high only while
// the sequencer is idle. The m_ channel delivers events in the order x, y,
// button, and last_of_run marks the final event of a request.
// A request with no motion and no button change gives no event.
// Per request the sequencer finds the magnitude, runs the power loop, sums
// the scale, multiplies x then y and posts the events; without acceleration
// it starts at the x multiply, and with no motion at posting. All work runs
// through one shared multiplier, one multiply per cycle; s_ready stays low
// until the request is done. The single output register holds an event
// while m_ready is low; emission waits on it, and a new request is taken
// once all events are loaded. Configuration registers sit on the APB port
// at byte addresses 0 to 20; the user must write them only while idle, and
// the block does not enforce it. Synchronous reset (aresetn low) restores
// the register defaults, clears the button state and drops pending events.
`timescale 1ns / 1ps
`default_nettype none

module trackball_motion_accelerator_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire tmau_pkg::tmau_in_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output tmau_pkg::tmau_out_t              m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tmau_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tmau_pkg::DATA_W-1:0] pwdata,
    output logic      [tmau_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import tmau_pkg::*;

    tmau_cfg_t cfg;

    tmau_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmau_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* dv/tb_trackball_motion_accelerator_unit.sv */
// Self-checking testbench for the trackball motion accelerator unit.
// Needs tmau_pkg and the RTL; a built-in predictor checks every event against
// directed and random trackball reads under many register settings.
`timescale 1ns / 1ps

module tb_trackball_motion_accelerator_unit;
    import tmau_pkg::*;

    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tmau_in_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    tmau_out_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    tmau_cfg_t   cfg;
    logic        button_down;
    tmau_in_t    pending_reads[$];
    tmau_out_t   expected_events[$];
    int          reads_queued   = 0;
    int          reads_accepted = 0;
    int          mismatches     = 0;
    int          send_wait      = 0;
    int          recv_wait      = 0;
    bit          send_quiet     = 1'b0;
    bit          recv_quiet     = 1'b0;

    trackball_motion_accelerator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int accel_gain(input int excess, input int expo);
        int acc;
        int k;
        acc = 1;
        if (excess == 0) begin
            return (expo == 0) ? 1 : 0;
        end
        for (k = 0; k < expo; k++) begin
            if (acc > int'(SCALE_LIMIT)) begin
                return int'(SCALE_LIMIT);
            end
            acc = acc * excess;
        end
        return (acc > int'(SCALE_LIMIT)) ? int'(SCALE_LIMIT) : acc;
    endfunction

    function automatic logic [15:0] scaled_axis(input int delta, input int scale);
        int p;
        p = (delta * scale) / 16;
        if (p > 32767) begin
            p = 32767;
        end
        if (p < -32768) begin
            p = -32768;
        end
        return p[15:0];
    endfunction

    function automatic void predict_events(input tmau_in_t rd);
        int          dx;
        int          dy;
        int          ax;
        int          ay;
        int          hi;
        int          lo;
        int          mag;
        int          excess;
        int          scale;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] tmp;
        logic        pressed;
        bit          has_x;
        bit          has_y;
        bit          has_b;
        tmau_out_t   ev;
        dx = int'(rd.right_count) - int'(rd.left_count);
        dy = int'(rd.down_count) - int'(rd.up_count);
        pressed = rd.switch_byte[BUTTON_BIT];
        ox = '0;
        oy = '0;
        if (dx != 0 || dy != 0) begin
            if (cfg.accel_power == 0 || cfg.accel_threshold == 0) begin
                scale = int'(cfg.base_gain);
            end else begin
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                hi = (ax > ay) ? ax : ay;
                lo = (ax > ay) ? ay : ax;
                mag = ((hi * 15) >> 4) + ((lo * 15) >> 5);
                excess = (mag > int'(cfg.accel_threshold)) ? mag - int'(cfg.accel_threshold) : 0;
                scale = int'(cfg.base_gain) + accel_gain(excess, int'(cfg.accel_power));
                if (scale > int'(SCALE_LIMIT)) begin
                    scale = int'(SCALE_LIMIT);
                end
            end
            ox = scaled_axis(dx, scale);
            oy = scaled_axis(dy, scale);
        end
        if (cfg.swap_axes) begin
            tmp = ox;
            ox = oy;
            oy = tmp;
        end
        if (cfg.negate_x) begin
            ox = 16'd0 - ox;
        end
        if (cfg.negate_y) begin
            oy = 16'd0 - oy;
        end
        has_x = (ox != 16'd0);
        has_y = (oy != 16'd0);
        has_b = (pressed != button_down);
        if (has_x) begin
            ev.event_kind  = KIND_REL_X;
            ev.event_value = ox;
            ev.sync_flag   = !has_y;
            ev.last_of_run = !has_y && !has_b;
            expected_events.push_back(ev);
        end
        if (has_y) begin
            ev.event_kind  = KIND_REL_Y;
            ev.event_value = oy;
            ev.sync_flag   = 1'b1;
            ev.last_of_run = !has_b;
            expected_events.push_back(ev);
        end
        if (has_b) begin
            ev.event_kind  = KIND_BUTTON;
            ev.event_value = {15'd0, pressed};
            ev.sync_flag   = 1'b1;
            ev.last_of_run = 1'b1;
            expected_events.push_back(ev);
            button_down = pressed;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_event(input tmau_out_t got);
        tmau_out_t want;
        if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d value %0d",
                                      got.event_kind, got.event_value));
        end else begin
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_mismatch($sformatf("event_kind %0d, want %0d",
                                          got.event_kind, want.event_kind));
            if (got.event_value !== want.event_value)
                report_mismatch($sformatf("event_value %0d, want %0d",
                                          got.event_value, want.event_value));
            if (got.sync_flag !== want.sync_flag)
                report_mismatch($sformatf("sync_flag %b, want %b",
                                          got.sync_flag, want.sync_flag));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %b, want %b",
                                          got.last_of_run, want.last_of_run));
        end
    endtask

    function automatic int pause_len(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_events(s_data);
                reads_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_reads.size() > 0) begin
                    s_data  <= pending_reads.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0) begin
                        send_quiet = !send_quiet;
                    end
                    send_wait = pause_len(send_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_event(m_data);
                if ($urandom_range(0, 31) == 0) begin
                    recv_quiet = !recv_quiet;
                end
                recv_wait = pause_len(recv_quiet);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE_GAIN:       cfg.base_gain       = value[15:0];
            REG_ACCEL_THRESHOLD: cfg.accel_threshold = value[15:0];
            REG_ACCEL_POWER:     cfg.accel_power     = value[7:0];
            REG_SWAP_AXES:       cfg.swap_axes       = value[0];
            REG_NEGATE_X:        cfg.negate_x        = value[0];
            REG_NEGATE_Y:        cfg.negate_y        = value[0];
            default: ;
        endcase
    endtask

    // Bits above the register width carry random junk that must be dropped.
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value, input int width);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        write_reg(idx, ($urandom() & ~mask) | (value & mask));
    endtask

    task automatic setup_regs(input logic [15:0] base, input logic [15:0] thresh,
                              input logic [7:0] power, input bit swap, input bit neg_x,
                              input bit neg_y);
        set_reg(REG_BASE_GAIN, base, 16);
        set_reg(REG_ACCEL_THRESHOLD, thresh, 16);
        set_reg(REG_ACCEL_POWER, power, 8);
        set_reg(REG_SWAP_AXES, swap, 1);
        set_reg(REG_NEGATE_X, neg_x, 1);
        set_reg(REG_NEGATE_Y, neg_y, 1);
        write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom());
    endtask

    task automatic queue_read(input logic [7:0] left, input logic [7:0] right,
                              input logic [7:0] up, input logic [7:0] down,
                              input logic [7:0] switches);
        pending_reads.push_back({left, right, up, down, switches});
        reads_queued++;
    endtask

    function automatic logic [7:0] motion_count();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'($urandom_range(0, 6));
            2: return 8'($urandom_range(250, 255));
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic queue_random_reads(input int count);
        tmau_in_t rd;
        int       i;
        for (i = 0; i < count; i++) begin
            rd.left_count  = motion_count();
            rd.right_count = motion_count();
            rd.up_count    = motion_count();
            rd.down_count  = motion_count();
            case ($urandom_range(0, 5))
                0: rd.right_count = rd.left_count;
                1: rd.down_count = rd.up_count;
                2: begin
                    rd.right_count = rd.left_count;
                    rd.down_count  = rd.up_count;
                end
                default: ;
            endcase
            rd.switch_byte = 8'($urandom());
            pending_reads.push_back(rd);
            reads_queued++;
        end
    endtask

    task automatic random_setup();
        logic [15:0] base;
        logic [15:0] thresh;
        logic [7:0]  power;
        case ($urandom_range(0, 3))
            0: base = 16'd0;
            1: base = 16'hFFFF;
            2: base = 16'($urandom_range(1, 64));
            default: base = 16'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0: thresh = 16'd0;
            1: thresh = 16'hFFFF;
            2: thresh = 16'($urandom_range(1, 360));
            default: thresh = 16'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0: power = 8'd0;
            1: power = 8'hFF;
            2: power = 8'($urandom_range(1, 5));
            default: power = 8'($urandom());
        endcase
        setup_regs(base, thresh, power, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1));
    endtask

    // A request may still be in flight with no event to show for it, so the
    // block is left to settle after the last expected event.
    task automatic settle();
        while (reads_accepted != reads_queued || expected_events.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        cfg = '{base_gain: 16'd16, accel_threshold: 16'd0, accel_power: 8'd0,
                swap_axes: 1'b0, negate_x: 1'b0, negate_y: 1'b0};
        button_down = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        queue_read(8'd0,   8'd0,   8'd0,   8'd0,   8'h00);
        queue_read(8'd0,   8'd255, 8'd0,   8'd0,   8'h00);
        queue_read(8'd255, 8'd0,   8'd0,   8'd0,   8'h00);
        queue_read(8'd0,   8'd0,   8'd0,   8'd255, 8'h00);
        queue_read(8'd0,   8'd0,   8'd255, 8'd0,   8'h80);
        queue_read(8'd100, 8'd100, 8'd7,   8'd7,   8'h80);
        queue_read(8'd3,   8'd250, 8'd200, 8'd1,   8'h7F);
        queue_read(8'd0,   8'd0,   8'd0,   8'd0,   8'hFF);
        queue_read(8'd1,   8'd0,   8'd0,   8'd1,   8'hFF);
        queue_read(8'd0,   8'd0,   8'd0,   8'd0,   8'h00);
        settle();

        setup_regs(16'd16, 16'd10, 8'd2, 1'b0, 1'b0, 1'b0);
        queue_read(8'd0, 8'd20,  8'd0, 8'd0,   8'h00);
        queue_read(8'd0, 8'd5,   8'd3, 8'd0,   8'h00);
        queue_read(8'd0, 8'd255, 8'd0, 8'd255, 8'h00);
        settle();

        setup_regs(16'hFFFF, 16'd1, 8'hFF, 1'b1, 1'b0, 1'b1);
        queue_read(8'd0, 8'd2,  8'd0, 8'd1, 8'h00);
        queue_read(8'd0, 8'd40, 8'd0, 8'd0, 8'h00);
        queue_read(8'd0, 8'd0,  8'd9, 8'd0, 8'h80);
        settle();

        setup_regs(16'hFFFF, 16'd0, 8'd0, 1'b0, 1'b1, 1'b1);
        queue_read(8'd255, 8'd0,   8'd255, 8'd0, 8'h00);
        queue_read(8'd0,   8'd255, 8'd0,   8'd0, 8'h80);
        settle();

        setup_regs(16'd0, 16'hFFFF, 8'd1, 1'b0, 1'b0, 1'b0);
        queue_read(8'd0, 8'd255, 8'd0, 8'd255, 8'h00);
        queue_read(8'd0, 8'd15,  8'd0, 8'd16,  8'h80);
        settle();

        setup_regs(16'd15, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_read(8'd20, 8'd0, 8'd0, 8'd16, 8'h00);
        queue_read(8'd0,  8'd1, 8'd1, 8'd0,  8'h00);
        settle();

        repeat (8) begin
            random_setup();
            queue_random_reads(60);
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS trackball_motion_accelerator_unit");
        end else begin
            $display("FAIL trackball_motion_accelerator_unit");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL trackball_motion_accelerator_unit");
        $finish;
    end

endmodule

/* sim.f */
sv/tmau_pkg.sv
sv/tmau_regs.sv
sv/tmau_mul.sv
sv/tmau_seq.sv
sv/trackball_motion_accelerator_unit.sv
dv/tb_trackball_motion_accelerator_unit.sv
